### rtl/core/uri_pkg.sv
// Package: shared types, constants and helpers of the UART register interface.
`timescale 1ns / 1ps
`default_nettype none

package uri_pkg;

  // Bus register addresses
  typedef enum logic [1:0] {
    ADDR_STATUS  = 2'd0,
    ADDR_DATA    = 2'd1,
    ADDR_COMMAND = 2'd2,
    ADDR_INTR    = 2'd3
  } reg_addr_e;

  // Request kind
  typedef enum logic {
    MODE_BUS  = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_INTERRUPT_LINE = 1'b0,
    CFG_EVEN_MODE      = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgDataWidth = 5;

  // Status byte bit positions
  localparam int unsigned StTbeBit = 7;
  localparam int unsigned StRdaBit = 6;
  localparam int unsigned StIpgBit = 5;

  // Command and mask bit positions
  localparam int unsigned CmdIntEnBit   = 3;
  localparam int unsigned CmdHighBdBit  = 4;
  localparam int unsigned MaskTxIeBit   = 5;
  localparam int unsigned MaskRxIeBit   = 4;
  localparam int unsigned FmtOneStopBit = 7;

  localparam logic [7:0] VecRx     = 8'hE7;
  localparam logic [7:0] VecTx     = 8'hEF;
  localparam logic [7:0] ReadIdle  = 8'hFF;
  localparam logic [2:0] Baud9600  = 3'd6;

  typedef struct packed {
    logic       mode;
    logic [1:0] reg_addr;
    logic       is_write;
    logic [7:0] write_data;
    logic       rx_present;
    logic [7:0] rx_char;
    logic       line_ready;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       irq;
    logic [7:0] irq_bus_byte;
    logic [2:0] baud_select;
    logic       two_stop;
    logic       high_baud;
  } rsp_t;

  // Architectural state; FME and ORE are never set, so they are not stored
  typedef struct packed {
    logic       tbe;
    logic       rda;
    logic       ipg;
    logic [7:0] rx_holding;
    logic [7:0] tx_holding;
    logic       tx_pending;
    logic       int_enable;
    logic [7:0] int_mask;
    logic [7:0] int_address;
    logic [2:0] baud_code;
    logic       stop_two;
    logic       rate_x8;
  } state_t;

  // One-hot baud code in bits 5..0; anything else selects 9600
  function automatic logic [2:0] decode_baud(input logic [7:0] v);
    logic [2:0] code;
    case (v[6:0])
      7'h01:   code = 3'd0;
      7'h02:   code = 3'd1;
      7'h04:   code = 3'd2;
      7'h08:   code = 3'd3;
      7'h10:   code = 3'd4;
      7'h20:   code = 3'd5;
      default: code = Baud9600;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### rtl/core/uri_step.sv
// Combinational update: next register state and result for one request.
`timescale 1ns / 1ps
`default_nettype none

module uri_step (
  input  uri_pkg::state_t st_i,
  input  uri_pkg::req_t   req_i,
  input  logic            even_mode_i,
  output uri_pkg::state_t st_o,
  output uri_pkg::rsp_t   rsp_o
);
  import uri_pkg::*;

  logic       raise_tx;
  logic       raise_rx;
  logic [7:0] vec_sel;

  always_comb begin
    st_o     = st_i;
    raise_tx = 1'b0;
    raise_rx = 1'b0;
    vec_sel  = st_i.int_address;
    rsp_o    = '0;
    rsp_o.read_data = ReadIdle;

    if (req_i.mode == MODE_BUS) begin
      // Decode the bus access
      case (reg_addr_e'(req_i.reg_addr))
        ADDR_STATUS: begin
          if (!req_i.is_write) begin
            rsp_o.read_data = {st_i.tbe, st_i.rda, st_i.ipg, 5'b0};
          end else begin
            st_o.stop_two  = ~req_i.write_data[FmtOneStopBit];
            st_o.baud_code = decode_baud(req_i.write_data);
          end
        end
        ADDR_DATA: begin
          if (!req_i.is_write) begin
            rsp_o.read_data = st_i.rx_holding;
            st_o.rda = 1'b0;
            st_o.ipg = 1'b0;
          end else begin
            st_o.tx_holding = req_i.write_data;
            st_o.tbe        = 1'b0;
            st_o.ipg        = 1'b0;
            st_o.tx_pending = 1'b1;
          end
        end
        ADDR_COMMAND: begin
          if (req_i.is_write) begin
            st_o.int_enable = req_i.write_data[CmdIntEnBit];
            st_o.rate_x8    = req_i.write_data[CmdHighBdBit];
          end
        end
        ADDR_INTR: begin
          if (!req_i.is_write) begin
            rsp_o.read_data = st_i.int_address;
          end else begin
            st_o.int_mask = req_i.write_data;
          end
        end
        default: ;
      endcase
    end else begin
      // Send the pending transmit byte
      if (st_i.tx_pending) begin
        rsp_o.tx_valid  = 1'b1;
        rsp_o.tx_char   = st_i.tx_holding;
        st_o.tx_pending = 1'b0;
        if (st_i.int_mask[MaskTxIeBit]) begin
          vec_sel  = VecTx;
          raise_tx = st_i.int_enable;
        end
      end
      // Mark the transmitter empty once the line is free
      if (!st_i.tbe && req_i.line_ready) begin
        st_o.tbe = 1'b1;
      end
      // Latch a received byte into an empty holding register
      if (!st_i.rda && req_i.rx_present) begin
        st_o.rx_holding = req_i.rx_char;
        st_o.rda        = 1'b1;
        if (st_i.int_mask[MaskRxIeBit]) begin
          vec_sel  = VecRx;
          raise_rx = st_i.int_enable;
        end
      end
      st_o.int_address = vec_sel;
      if (raise_tx || raise_rx) begin
        st_o.ipg           = 1'b1;
        rsp_o.irq          = 1'b1;
        rsp_o.irq_bus_byte = {vec_sel[7:1], vec_sel[0] & ~even_mode_i};
      end
    end

    rsp_o.baud_select = st_o.baud_code;
    rsp_o.two_stop    = st_o.stop_two;
    rsp_o.high_baud   = st_o.rate_x8;
  end

endmodule

`default_nettype wire

### rtl/core/uart_register_interface.sv
// Top level: UART register block with request and result channels.
//
// Usage:
//   Requests enter on in_valid_i/in_ready_o carrying a uri_pkg::req_t: a bus
//   access (read or write of one of four registers) or a service tick that
//   moves a pending transmit byte to the line and latches a received byte.
//   Each request gives exactly one result on out_valid_o/out_ready_i as a
//   uri_pkg::rsp_t: read data, the transmit character, the interrupt strobe
//   with its acknowledge byte, and the current line format.
//   The register state is updated and the result is captured in the output
//   register on the accepting edge.
//   Throughput is one request per cycle; the single output register lets a
//   new request in whenever the held result is taken in the same cycle.
//   When the receiver stalls, the result is held and in_ready_o drops, so
//   no request is accepted and the register state does not move.
//   Reset clears all state (baud code goes to 9600) and empties the output.
//   The configuration port writes the interrupt line number and even mode;
//   the user must do so only while idle; the block does not enforce it.
//   The line number is not stored here; even mode alone affects the ack byte.
`timescale 1ns / 1ps
`default_nettype none

module uart_register_interface (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  uri_pkg::req_t                        in_req_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output uri_pkg::rsp_t                        out_rsp_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [uri_pkg::CfgDataWidth-1:0]     cfg_wdata_i
);
  import uri_pkg::*;

  state_t st_q, st_d;
  rsp_t   rsp_q, rsp_d;
  logic   out_valid_q;
  logic   even_mode_q;
  logic   accept;

  // Take a request when the output slot is free or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  uri_step u_step (
    .st_i        (st_q),
    .req_i       (in_req_i),
    .even_mode_i (even_mode_q),
    .st_o        (st_d),
    .rsp_o       (rsp_d)
  );

  // Hold the even mode configuration bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_mode_q <= 1'b0;
    end else if (cfg_we_i && cfg_idx_e'(cfg_idx_i) == CFG_EVEN_MODE) begin
      even_mode_q <= cfg_wdata_i[0];
    end
  end

  // Advance register state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{baud_code: Baud9600, default: '0};
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  // Output slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Every accepted request shows a result next cycle
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no result");

  // A shown transmit means the pending byte is gone
  a_tx_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.tx_valid) |-> !st_q.tx_pending)
    else $error("transmit shown while byte still pending");

  // A shown interrupt leaves interrupt-pending set
  a_irq_sets_ipg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.irq) |-> (st_q.ipg && st_q.int_enable))
    else $error("interrupt shown without IPG or enable");

  // No acknowledge byte without an interrupt
  a_irq_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.irq) |-> (out_rsp_o.irq_bus_byte == 8'h00))
    else $error("acknowledge byte without interrupt");

  // Baud code stays in range
  a_baud_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.baud_select != 3'd7))
    else $error("baud select out of range");

endmodule

`default_nettype wire
